@@ rtl/sdm_pkg.sv @@
package sdm_pkg;

    localparam int MantBits  = 96;
    localparam int WideBits  = 192;
    localparam int MaxScale  = 28;
    localparam int ScaleBits = 5;
    localparam int SumBits   = 6;
    localparam int DigitBits = 4;
    localparam int BitCntW   = 8;

    typedef enum logic [1:0] {
        OUT_OK       = 2'd0,
        OUT_OVERFLOW = 2'd1,
        OUT_ZERO     = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [63:0] a_mantissa_low;
        logic [31:0] a_mantissa_high;
        logic [4:0]  a_scale;
        logic        a_negative;
        logic [63:0] b_mantissa_low;
        logic [31:0] b_mantissa_high;
        logic [4:0]  b_scale;
        logic        b_negative;
    } t_in_req;

    typedef struct packed {
        logic [63:0] product_mantissa_low;
        logic [31:0] product_mantissa_high;
        logic [4:0]  product_scale;
        logic        product_negative;
        logic [1:0]  outcome;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_ROUND,
        ST_INC,
        ST_FIXUP,
        ST_RDIV,
        ST_DONE
    } t_state;

    // control from sequencer to the serial divide-by-ten unit
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ rtl/sdm_div10.sv @@
// bit-serial divide by ten, msb first, one quotient bit per cycle
module sdm_div10 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sdm_pkg::t_div_ctl                   i_ctl,
    input  logic [sdm_pkg::WideBits-1:0]        i_value,
    output sdm_pkg::t_div_sts                   o_sts,
    output logic [sdm_pkg::WideBits-1:0]        o_quot,
    output logic [sdm_pkg::DigitBits-1:0]       o_rem
);

    logic [sdm_pkg::WideBits-1:0]  r_sh, n_sh;
    logic [sdm_pkg::DigitBits-1:0] r_rem, n_rem;
    logic [sdm_pkg::BitCntW-1:0]   r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [sdm_pkg::DigitBits:0]   w_trial;

    always_comb begin
        n_sh    = r_sh;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_sh[sdm_pkg::WideBits-1]};
        if (i_ctl.start) begin
            n_sh   = i_value;
            n_rem  = '0;
            n_cnt  = sdm_pkg::BitCntW'(sdm_pkg::WideBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= 5'd10) begin
                n_rem = sdm_pkg::DigitBits'(w_trial - 5'd10);
                n_sh  = {r_sh[sdm_pkg::WideBits-2:0], 1'b1};
            end else begin
                n_rem = w_trial[sdm_pkg::DigitBits-1:0];
                n_sh  = {r_sh[sdm_pkg::WideBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == sdm_pkg::BitCntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_quot      = r_sh;
    assign o_rem       = r_rem;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;

`ifndef ASSERT_OFF
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < 4'd10) else $error("remainder out of range");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.start) else $error("start while busy");
`endif

endmodule

@@ rtl/scaled_decimal_multiply.sv @@
// sequence: a serial shift-and-add multiply over the 96 bits of b, then as many divide-by-ten
// passes (check, serial divide over 192 bits, done) as the scale needs, and a rounding
// step that retries with a further pass when its carry spills past 96 bits
// throughput: one request at a time, o_stall high until the sequencer returns to idle; the
// divide-by-ten unit is bit-serial, one bit per cycle over 192 bits
// reset: synchronous active-low i_rst_n returns the sequencer to idle, output empty
module scaled_decimal_multiply (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sdm_pkg::t_in_req  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output sdm_pkg::t_out_req o_data
);

    localparam int W = sdm_pkg::WideBits;
    localparam int M = sdm_pkg::MantBits;

    sdm_pkg::t_state r_state, n_state;

    logic [W-1:0]                  r_acc, n_acc;
    logic [W-1:0]                  r_a, n_a;
    logic [M-1:0]                  r_b, n_b;
    logic [sdm_pkg::BitCntW-1:0]   r_cnt, n_cnt;
    logic [sdm_pkg::SumBits-1:0]   r_scale, n_scale;
    logic [sdm_pkg::DigitBits-1:0] r_digit, n_digit;
    logic                          r_reduced, n_reduced;
    logic                          r_neg, n_neg;
    logic                          r_ovf, n_ovf;
    logic                          r_ovalid, n_ovalid;
    sdm_pkg::t_out_req             r_out, n_out;

    sdm_pkg::t_div_ctl             w_dctl;
    sdm_pkg::t_div_sts             w_dsts;
    logic [W-1:0]                  w_quot;
    logic [sdm_pkg::DigitBits-1:0] w_rem;
    logic                          w_wide;
    logic                          w_round;

    sdm_div10 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dctl),
        .i_value (r_acc),
        .o_sts   (w_dsts),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    assign w_wide  = |r_acc[W-1:M];
    assign w_round = (r_digit > 4'd5) || (r_digit == 4'd5 && r_acc[0]);

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt     = r_cnt;
        n_scale   = r_scale;
        n_digit   = r_digit;
        n_reduced = r_reduced;
        n_neg     = r_neg;
        n_ovf     = r_ovf;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        w_dctl.start = 1'b0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            sdm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_acc     = '0;
                    n_a       = {(W-M)'(0), i_data.a_mantissa_high, i_data.a_mantissa_low};
                    n_b       = {i_data.b_mantissa_high, i_data.b_mantissa_low};
                    n_cnt     = sdm_pkg::BitCntW'(M);
                    n_scale   = sdm_pkg::SumBits'(i_data.a_scale)
                              + sdm_pkg::SumBits'(i_data.b_scale);
                    n_neg     = i_data.a_negative ^ i_data.b_negative;
                    n_reduced = 1'b0;
                    n_ovf     = 1'b0;
                    n_digit   = '0;
                    n_state   = sdm_pkg::ST_MUL;
                end
            end
            sdm_pkg::ST_MUL: begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a   = {r_a[W-2:0], 1'b0};
                n_b   = {1'b0, r_b[M-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == sdm_pkg::BitCntW'(1)) n_state = sdm_pkg::ST_CHECK;
            end
            sdm_pkg::ST_CHECK: begin
                if (r_scale != '0 &&
                    (w_wide || r_scale > sdm_pkg::SumBits'(sdm_pkg::MaxScale))) begin
                    w_dctl.start = 1'b1;
                    n_state = sdm_pkg::ST_DIV;
                end else if (w_wide) begin
                    n_ovf   = 1'b1;
                    n_state = sdm_pkg::ST_DONE;
                end else if (r_reduced) begin
                    n_state = sdm_pkg::ST_ROUND;
                end else begin
                    n_state = sdm_pkg::ST_DONE;
                end
            end
            sdm_pkg::ST_DIV: begin
                if (w_dsts.done) begin
                    n_acc     = w_quot;
                    n_digit   = w_rem;
                    n_scale   = r_scale - 1'b1;
                    n_reduced = 1'b1;
                    n_state   = sdm_pkg::ST_CHECK;
                end
            end
            sdm_pkg::ST_ROUND: begin
                if (w_round) begin
                    n_acc   = r_acc + 1'b1;
                    n_state = sdm_pkg::ST_INC;
                end else begin
                    n_state = sdm_pkg::ST_DONE;
                end
            end
            sdm_pkg::ST_INC: begin
                if (!w_wide) begin
                    n_state = sdm_pkg::ST_DONE;
                end else begin
                    n_acc   = r_acc - 1'b1;
                    n_state = sdm_pkg::ST_FIXUP;
                end
            end
            sdm_pkg::ST_FIXUP: begin
                if (r_scale == '0) begin
                    n_ovf   = 1'b1;
                    n_state = sdm_pkg::ST_DONE;
                end else begin
                    w_dctl.start = 1'b1;
                    n_state = sdm_pkg::ST_RDIV;
                end
            end
            sdm_pkg::ST_RDIV: begin
                if (w_dsts.done) begin
                    n_acc   = w_quot;
                    n_digit = w_rem;
                    n_scale = r_scale - 1'b1;
                    n_state = sdm_pkg::ST_ROUND;
                end
            end
            sdm_pkg::ST_DONE: begin
                // output register must be free before the result is loaded
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_out.product_negative = r_neg;
                    if (r_ovf) begin
                        n_out.product_mantissa_low  = '0;
                        n_out.product_mantissa_high = '0;
                        n_out.product_scale         = '0;
                        n_out.outcome               = sdm_pkg::OUT_OVERFLOW;
                    end else begin
                        n_out.product_mantissa_low  = r_acc[63:0];
                        n_out.product_mantissa_high = r_acc[M-1:64];
                        n_out.product_scale         = r_scale[sdm_pkg::ScaleBits-1:0];
                        n_out.outcome = (r_acc == '0) ? sdm_pkg::OUT_ZERO
                                                      : sdm_pkg::OUT_OK;
                    end
                    n_state = sdm_pkg::ST_IDLE;
                end
            end
            default: n_state = sdm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sdm_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_acc     <= n_acc;
        r_a       <= n_a;
        r_b       <= n_b;
        r_cnt     <= n_cnt;
        r_scale   <= n_scale;
        r_digit   <= n_digit;
        r_reduced <= n_reduced;
        r_neg     <= n_neg;
        r_ovf     <= n_ovf;
        r_out     <= n_out;
    end

    assign o_stall = (r_state != sdm_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    a_scale_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdm_pkg::ST_DONE && !r_ovf) |-> r_scale <= 6'd28)
        else $error("scale above limit at result");
    a_fits_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdm_pkg::ST_DONE && !r_ovf) |-> !w_wide)
        else $error("mantissa too wide at result");
    a_ovf_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.outcome == sdm_pkg::OUT_OVERFLOW) |->
        (o_data.product_scale == '0)) else $error("overflow with nonzero scale");
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdm_pkg::ST_ROUND) |-> r_digit < 4'd10)
        else $error("rounding digit out of range");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int WatchLimit = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    sdm_pkg::t_in_req  i_data = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    sdm_pkg::t_out_req o_data;

    scaled_decimal_multiply dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    sdm_pkg::t_out_req product_queue[$];
    int         fail_count = 0;
    int         result_count = 0;
    int         overflow_count = 0;
    int         zero_count = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function automatic logic [191:0] div_by_ten(input logic [191:0] v, output logic [3:0] dig);
        logic [191:0] rem;
        rem = v % 192'd10;
        dig = rem[3:0];
        return v / 192'd10;
    endfunction

    function automatic sdm_pkg::t_out_req predict_product(input sdm_pkg::t_in_req r);
        sdm_pkg::t_out_req p;
        logic [191:0]   acc;
        logic [191:0]   a_full;
        logic [191:0]   b_full;
        logic [3:0]     dig;
        logic [6:0]     sc;
        logic           reduced;
        logic           ovf;
        a_full = {96'd0, r.a_mantissa_high, r.a_mantissa_low};
        b_full = {96'd0, r.b_mantissa_high, r.b_mantissa_low};
        acc = a_full * b_full;
        sc = r.a_scale + r.b_scale;
        reduced = 1'b0;
        dig = '0;
        while (sc > 0 && (acc[191:96] != 0 || sc > sdm_pkg::MaxScale)) begin
            acc = div_by_ten(acc, dig);
            sc = sc - 7'd1;
            reduced = 1'b1;
        end
        ovf = acc[191:96] != 0;
        if (!ovf && reduced) begin
            while (dig > 5 || (dig == 5 && acc[0])) begin
                if (acc[95:0] != {96{1'b1}}) begin
                    acc = acc + 1;
                    break;
                end
                // carry into bit 96: drop another digit instead
                if (sc == 0) begin
                    ovf = 1'b1;
                    break;
                end
                acc = div_by_ten(acc, dig);
                sc = sc - 7'd1;
            end
        end
        p = '0;
        p.product_negative = r.a_negative ^ r.b_negative;
        if (ovf) begin
            p.outcome = sdm_pkg::OUT_OVERFLOW;
        end else begin
            p.product_mantissa_low = acc[63:0];
            p.product_mantissa_high = acc[95:64];
            p.product_scale = sc[4:0];
            p.outcome = (acc == 0) ? sdm_pkg::OUT_ZERO : sdm_pkg::OUT_OK;
        end
        return p;
    endfunction

    // typed-in rows carry their expected product, the others are predicted
    typedef struct {
        sdm_pkg::t_in_req  req;
        logic              typed;
        sdm_pkg::t_out_req want;
    } t_row;

    function automatic sdm_pkg::t_in_req make_req(input logic [95:0] am, input int as,
                                                  input logic an, input logic [95:0] bm,
                                                  input int bs, input logic bn);
        sdm_pkg::t_in_req r;
        r.a_mantissa_low = am[63:0];
        r.a_mantissa_high = am[95:64];
        r.a_scale = as[4:0];
        r.a_negative = an;
        r.b_mantissa_low = bm[63:0];
        r.b_mantissa_high = bm[95:64];
        r.b_scale = bs[4:0];
        r.b_negative = bn;
        return r;
    endfunction

    function automatic sdm_pkg::t_out_req make_out(input logic [95:0] m, input int s,
                                                   input logic n, input sdm_pkg::t_outcome o);
        sdm_pkg::t_out_req p;
        p.product_mantissa_low = m[63:0];
        p.product_mantissa_high = m[95:64];
        p.product_scale = s[4:0];
        p.product_negative = n;
        p.outcome = o;
        return p;
    endfunction

    t_row stim_table[$];

    initial begin
        logic [95:0] ones;
        ones = {96{1'b1}};
        stim_table.push_back('{make_req(0, 0, 0, 0, 0, 0), 1,
                               make_out(0, 0, 0, sdm_pkg::OUT_ZERO)});
        stim_table.push_back('{make_req(0, 28, 1, ones, 28, 0), 1,
                               make_out(0, 28, 1, sdm_pkg::OUT_ZERO)});
        stim_table.push_back('{make_req(1, 0, 0, 1, 0, 0), 1,
                               make_out(1, 0, 0, sdm_pkg::OUT_OK)});
        stim_table.push_back('{make_req(1, 0, 1, 1, 0, 1), 1,
                               make_out(1, 0, 0, sdm_pkg::OUT_OK)});
        stim_table.push_back('{make_req(7, 3, 1, 6, 2, 0), 1,
                               make_out(42, 5, 1, sdm_pkg::OUT_OK)});
        stim_table.push_back('{make_req(ones, 0, 0, 2, 0, 1), 1,
                               make_out(0, 0, 1, sdm_pkg::OUT_OVERFLOW)});
        stim_table.push_back('{make_req(ones, 0, 0, ones, 0, 0), 1,
                               make_out(0, 0, 0, sdm_pkg::OUT_OVERFLOW)});
        stim_table.push_back('{make_req(ones, 28, 0, ones, 28, 1), 0, '0});
        stim_table.push_back('{make_req(ones, 1, 0, ones, 0, 0), 0, '0});
        stim_table.push_back('{make_req(ones, 31, 0, ones, 31, 0), 0, '0});
        stim_table.push_back('{make_req(1, 31, 0, 1, 31, 0), 0, '0});
        // rounding cases: drop a five with even and odd kept digit, then a six and a four
        stim_table.push_back('{make_req(25, 15, 0, 1, 14, 0), 0, '0});
        stim_table.push_back('{make_req(35, 15, 0, 1, 14, 0), 0, '0});
        stim_table.push_back('{make_req(26, 15, 0, 1, 14, 1), 0, '0});
        stim_table.push_back('{make_req(24, 15, 0, 1, 14, 0), 0, '0});
        // scale pushes a tiny value to zero
        stim_table.push_back('{make_req(4, 20, 0, 1, 20, 1), 0, '0});
        // wide products that need reducing back under 96 bits, or overflow
        stim_table.push_back('{make_req(ones, 0, 0, 10, 1, 0), 0, '0});
        stim_table.push_back('{make_req(96'h2_0000_0000_0000_0000_0000, 0, 0, ones, 1, 0),
                               0, '0});
        stim_table.push_back('{make_req(ones, 28, 1, 1, 28, 1), 0, '0});
        stim_table.push_back('{make_req(96'h8000_0000_0000_0000_0000_0000, 5, 0,
                                        96'h1_0000_0000, 9, 0), 0, '0});
    end

    function automatic logic [95:0] rand_mant();
        logic [95:0] m;
        int          w;
        m = {$urandom(), $urandom(), $urandom()};
        w = $urandom_range(0, 96);
        case ($urandom_range(0, 3))
            0: m = (w == 96) ? m : (m & ((96'd1 << w) - 1));
            1: m = m & 96'hFFFF;
            default: ;
        endcase
        return m;
    endfunction

    function automatic sdm_pkg::t_in_req rand_req();
        int sa;
        int sb;
        sa = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 28);
        sb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12);
        return make_req(rand_mant(), sa, 1'($urandom_range(0, 1)), rand_mant(), sb,
                        1'($urandom_range(0, 1)));
    endfunction

    task automatic send_request(input sdm_pkg::t_in_req r);
        while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        product_queue.push_back(predict_product(r));
    endtask

    task automatic drain_products();
        i_valid <= 1'b0;
        while (product_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= (recv_stall_pct != 0) && ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sdm_pkg::t_out_req want;
            if (product_queue.size() == 0) begin
                $error("unexpected product %h", o_data);
                fail_count++;
            end else begin
                want = product_queue.pop_front();
                result_count++;
                if (want.outcome == sdm_pkg::OUT_OVERFLOW) overflow_count++;
                if (want.outcome == sdm_pkg::OUT_ZERO) zero_count++;
                if (o_data.product_mantissa_low !== want.product_mantissa_low) begin
                    $error("product_mantissa_low exp %h got %h",
                           want.product_mantissa_low, o_data.product_mantissa_low);
                    fail_count++;
                end
                if (o_data.product_mantissa_high !== want.product_mantissa_high) begin
                    $error("product_mantissa_high exp %h got %h",
                           want.product_mantissa_high, o_data.product_mantissa_high);
                    fail_count++;
                end
                if (o_data.product_scale !== want.product_scale) begin
                    $error("product_scale exp %0d got %0d",
                           want.product_scale, o_data.product_scale);
                    fail_count++;
                end
                if (o_data.product_negative !== want.product_negative) begin
                    $error("product_negative exp %0d got %0d",
                           want.product_negative, o_data.product_negative);
                    fail_count++;
                end
                if (o_data.outcome !== want.outcome) begin
                    $error("outcome exp %0d got %0d", want.outcome, o_data.outcome);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        sdm_pkg::t_in_req r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (stim_table[k]) begin
            send_request(stim_table[k].req);
            // typed-in rows replace the predicted value
            if (stim_table[k].typed) product_queue[$] = stim_table[k].want;
        end
        drain_products();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 140; n++) begin
                r = rand_req();
                send_request(r);
            end
            // hold the sender until the block has drained
            drain_products();
        end
        recv_stall_pct = 0;
        $display("covered %0d products: %0d overflow, %0d zero, under five idle/stall mixes",
                 result_count, overflow_count, zero_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
